// ===== hw/rtl/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude block.
// Used by the controller, the datapath and the top level; depends on nothing.
package sem_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = 11;
	localparam int HGT_W      = 13;
	localparam int ROW_W      = 13;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int ROOT_STEPS = CH_W;
	localparam int STEP_W     = $clog2(ROOT_STEPS);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

	localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd1024;
	localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd768;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic              capture;
		logic              lookup;
		logic              grad;
		logic              square;
		logic              root;
		logic [STEP_W-1:0] root_idx;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic has_result;
		logic out_free;
	} status_t;

endpackage

// ===== hw/rtl/sem_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module sem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/sem_ctrl.sv =====
// Controller state machine sequencing lookup, gradient, square and root steps.
// Depends on sem_pkg.
module sem_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_stall,
	input  sem_pkg::status_t status,
	output sem_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_GRAD,
		ST_SQUARE,
		ST_ROOT,
		ST_HOLD
	} state_t;

	state_t                      state_q;
	logic [sem_pkg::STEP_W-1:0]  step_q;
	logic                        accept;

	assign pix_stall = (state_q != ST_IDLE);
	assign accept    = pix_valid && !pix_stall;

	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.lookup   = (state_q == ST_LOOKUP);
		cmd.grad     = (state_q == ST_GRAD);
		cmd.square   = (state_q == ST_SQUARE);
		cmd.root     = (state_q == ST_ROOT);
		cmd.root_idx = step_q;
		cmd.out_load = (state_q == ST_HOLD) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					state_q <= status.has_result ? ST_GRAD : ST_IDLE;
				end
				ST_GRAD: begin
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					state_q <= ST_ROOT;
					step_q  <= '0;
				end
				ST_ROOT: begin
					step_q <= step_q + 1'b1;
					if (step_q == sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_LOOKUP)
		else $error("accepted item did not enter lookup");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP && !status.has_result) |=> state_q == ST_IDLE)
		else $error("item without result did not return to idle");

	a_root_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT && step_q == sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1))
		|=> state_q == ST_HOLD)
		else $error("root iteration did not finish after its last step");

endmodule

// ===== hw/rtl/sem_datapath.sv =====
// Datapath: frame counters, line stores, 3x3 window, Sobel gradients,
// bit-serial square root and output register. Depends on sem_pkg and sem_ram.
module sem_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sem_pkg::cmd_t                    cmd,
	output sem_pkg::status_t                 status,
	input  logic                             command,
	input  logic [sem_pkg::CH_W-1:0]         red_in,
	input  logic [sem_pkg::CH_W-1:0]         green_in,
	input  logic [sem_pkg::CH_W-1:0]         blue_in,
	input  logic                             cfg_valid,
	input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             res_valid,
	input  logic                             res_stall,
	output logic [sem_pkg::CH_W-1:0]         red_edge,
	output logic [sem_pkg::CH_W-1:0]         green_edge,
	output logic [sem_pkg::CH_W-1:0]         blue_edge,
	output logic                             end_of_row,
	output logic                             end_of_frame
);

	localparam int CW = sem_pkg::CH_W;
	localparam int GW = CW + 3;
	localparam int NW = 2 * GW - 1;

	logic [sem_pkg::WID_W-1:0] fw_q, w_eff;
	logic [sem_pkg::HGT_W-1:0] fh_q, h_eff;
	logic [sem_pkg::COL_W-1:0] ic_q, oc_q;
	logic [sem_pkg::ROW_W-1:0] ir_q, or_q;
	logic                      cmd_q;
	sem_pkg::pix_t             pix_q;
	sem_pkg::pix_t             win_q [9];
	sem_pkg::pix_t             new_win [9];
	sem_pkg::pix_t             shift_win [9];
	sem_pkg::pix_t             col [3];
	sem_pkg::pix_t             upper_rd, middle_rd;
	sem_pkg::pix_t             mat_s1 [9];
	logic                      eor_s1, eof_s1;
	logic signed [GW-1:0]      gx_s2 [3];
	logic signed [GW-1:0]      gy_s2 [3];
	logic signed [GW-1:0]      gx_c [3];
	logic signed [GW-1:0]      gy_c [3];
	logic [NW-1:0]             n_s3 [3];
	logic [CW-1:0]             r_q [3];
	logic [CW-1:0]             bit_sel;
	logic                      lt_h, skip, past_end, ic0, edge_emit, main_step, norm_emit;
	logic                      has_result, eor, eof, line_wr;
	logic                      res_valid_q;

	assign w_eff = (fw_q == '0) ? sem_pkg::WID_W'(1) :
		(fw_q > sem_pkg::WID_W'(sem_pkg::MAX_WIDTH)) ? sem_pkg::WID_W'(sem_pkg::MAX_WIDTH) : fw_q;
	assign h_eff = (fh_q == '0) ? sem_pkg::HGT_W'(1) : fh_q;

	assign lt_h      = ir_q < h_eff;
	assign skip      = lt_h && cmd_q;
	assign past_end  = ir_q > h_eff;
	assign ic0       = (ic_q == '0);
	assign edge_emit = !skip && ic0 && (ir_q >= sem_pkg::ROW_W'(2));
	assign main_step = !skip && !past_end;
	assign norm_emit = main_step && !ic0 && (ir_q >= sem_pkg::ROW_W'(1));
	assign has_result = edge_emit || norm_emit;
	assign eor = ({1'b0, oc_q} == (w_eff - sem_pkg::WID_W'(1)));
	assign eof = eor && (or_q == (h_eff - sem_pkg::HGT_W'(1)));
	assign line_wr = cmd.lookup && main_step && lt_h;

	assign status.has_result = has_result;
	assign status.out_free   = !res_valid_q || !res_stall;

	always_comb begin
		col[0] = (ir_q >= sem_pkg::ROW_W'(2)) ? upper_rd : '0;
		col[1] = (ir_q >= sem_pkg::ROW_W'(1)) ? middle_rd : '0;
		col[2] = lt_h ? pix_q : '0;
		for (int k = 0; k < 3; k++) begin
			new_win[k*3+0]   = ic0 ? '0 : win_q[k*3+1];
			new_win[k*3+1]   = ic0 ? '0 : win_q[k*3+2];
			new_win[k*3+2]   = col[k];
			shift_win[k*3+0] = win_q[k*3+1];
			shift_win[k*3+1] = win_q[k*3+2];
			shift_win[k*3+2] = '0;
		end
	end

	sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_upper (
		.clk     (clk),
		.wr_en   (line_wr),
		.wr_addr (ic_q),
		.wr_data (middle_rd),
		.rd_en   (cmd.capture),
		.rd_addr (ic_q),
		.rd_data (upper_rd)
	);

	sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_middle (
		.clk     (clk),
		.wr_en   (line_wr),
		.wr_addr (ic_q),
		.wr_data (pix_q),
		.rd_en   (cmd.capture),
		.rd_addr (ic_q),
		.rd_data (middle_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= sem_pkg::WIDTH_RESET;
			fh_q <= sem_pkg::HEIGHT_RESET;
			ic_q <= '0;
			ir_q <= '0;
			oc_q <= '0;
			or_q <= '0;
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				sem_pkg::CFG_FRAME_WIDTH:  fw_q <= cfg_data[sem_pkg::WID_W-1:0];
				sem_pkg::CFG_FRAME_HEIGHT: fh_q <= cfg_data[sem_pkg::HGT_W-1:0];
				default: ;
			endcase
			ic_q <= '0;
			ir_q <= '0;
			oc_q <= '0;
			or_q <= '0;
		end else if (cmd.lookup) begin
			if (has_result) begin
				if (eor) begin
					oc_q <= '0;
					or_q <= or_q + 1'b1;
				end else begin
					oc_q <= oc_q + 1'b1;
				end
			end
			if (!skip && past_end) begin
				ic_q <= '0;
				ir_q <= '0;
				oc_q <= '0;
				or_q <= '0;
			end else if (main_step) begin
				win_q <= new_win;
				if (({1'b0, ic_q} + sem_pkg::WID_W'(1)) >= w_eff) begin
					ic_q <= '0;
					ir_q <= ir_q + 1'b1;
				end else begin
					ic_q <= ic_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= command;
			pix_q <= {red_in, green_in, blue_in};
		end
		if (cmd.lookup) begin
			mat_s1 <= edge_emit ? shift_win : new_win;
			eor_s1 <= eor;
			eof_s1 <= eof;
		end
	end

	always_comb begin
		logic [GW-1:0] v [9];
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < 9; i++) begin
				v[i] = GW'(mat_s1[i][(2-c)*CW +: CW]);
			end
			gx_c[c] = $signed((v[2] + (v[5] << 1) + v[8]) - (v[0] + (v[3] << 1) + v[6]));
			gy_c[c] = $signed((v[6] + (v[7] << 1) + v[8]) - (v[0] + (v[1] << 1) + v[2]));
		end
	end

	assign bit_sel = CW'(1) << (sem_pkg::STEP_W'(sem_pkg::ROOT_STEPS - 1) - cmd.root_idx);

	always_ff @(posedge clk) begin
		logic [CW-1:0]   t;
		logic [2*CW-1:0] q;
		if (cmd.grad) begin
			gx_s2 <= gx_c;
			gy_s2 <= gy_c;
		end
		for (int c = 0; c < 3; c++) begin
			t = r_q[c] | bit_sel;
			q = (t * t) - (2*CW)'(t);
			if (cmd.square) begin
				n_s3[c] <= NW'(gx_s2[c] * gx_s2[c] + gy_s2[c] * gy_s2[c]);
				r_q[c]  <= '0;
			end else if (cmd.root && (NW'(q) < n_s3[c])) begin
				r_q[c] <= t;
			end
		end
		if (cmd.out_load) begin
			red_edge     <= r_q[0];
			green_edge   <= r_q[1];
			blue_edge    <= r_q[2];
			end_of_row   <= eor_s1;
			end_of_frame <= eof_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

// ===== hw/rtl/sobel_edge_magnitude_rgb.sv =====
// Top level of the RGB Sobel edge magnitude block.
// Depends on sem_pkg, sem_ctrl and sem_datapath.
//
//   Channel  Handshake              Payload
//   pixel    pix_valid / pix_stall  command, red_in, green_in, blue_in
//   result   res_valid / res_stall  red_edge, green_edge, blue_edge, end_of_row, end_of_frame
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item that yields no result returns to idle after the line store read; one that yields a result
// then passes through gradient and square and the eight-step square root.
// One item is in work at a time; the output register holds a finished result while the next
// item is taken. A result waits in the final hold state while the output register is stalled.
// Reset restores the register defaults and clears counters and the window; line stores are
// not cleared.
module sobel_edge_magnitude_rgb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  logic                                command,
	input  logic [sem_pkg::CH_W-1:0]            red_in,
	input  logic [sem_pkg::CH_W-1:0]            green_in,
	input  logic [sem_pkg::CH_W-1:0]            blue_in,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [sem_pkg::CH_W-1:0]            red_edge,
	output logic [sem_pkg::CH_W-1:0]            green_edge,
	output logic [sem_pkg::CH_W-1:0]            blue_edge,
	output logic                                end_of_row,
	output logic                                end_of_frame,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sem_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0]      cfg_data
);

	sem_pkg::cmd_t    cmd;
	sem_pkg::status_t status;

	assign cfg_ready = 1'b1;

	sem_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sem_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.command      (command),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.red_edge     (red_edge),
		.green_edge   (green_edge),
		.blue_edge    (blue_edge),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

endmodule

// ===== test/testbench.sv =====
// Testbench for sobel_edge_magnitude_rgb: directed frames from a table, then random frames.
// Results are checked against an in-bench Sobel magnitude predictor or table; uses sem_pkg.
`timescale 1ns / 100ps

module testbench;
	import sem_pkg::*;

	localparam bit CMD_PIXEL = 1'b0;
	localparam bit CMD_FLUSH = 1'b1;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       eor;
		logic       eof;
	} edge_res_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		bit                    cmd;
		logic [23:0]           pix;
		bit                    known;
		edge_res_t             res;
	} stim_row_t;

	typedef logic [23:0] win_t [9];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic command = 1'b0;
	logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
	logic res_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic pix_stall, res_valid, cfg_ready, end_of_row, end_of_frame;
	logic [7:0] red_edge, green_edge, blue_edge;

	sobel_edge_magnitude_rgb dut (.*);

	always #4 clk = ~clk;

	edge_res_t edge_q [$];
	bit failed = 1'b0;
	bit quiet = 1'b0;
	int items_sent = 0;

	int unsigned cur_width = 1024, cur_height = 768;
	logic [23:0] upper_row [1024];
	logic [23:0] middle_row [1024];
	win_t window;
	int unsigned in_col, in_row, out_col, out_row;

	function automatic logic [7:0] chan_mag(win_t m, int sh);
		int gx, gy, v;
		int unsigned n, r, t;
		int kx [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
		int ky [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
		gx = 0;
		gy = 0;
		r = 0;
		for (int i = 0; i < 9; i++) begin
			v = (m[i] >> sh) & 8'hFF;
			gx += v * kx[i];
			gy += v * ky[i];
		end
		n = gx * gx + gy * gy;
		for (int b = 128; b != 0; b >>= 1) begin
			t = r | b;
			if (t * t - t < n)
				r = t;
		end
		return r[7:0];
	endfunction

	function automatic void push_edge(win_t m, int unsigned w, int unsigned h);
		edge_res_t e;
		e.red = chan_mag(m, 16);
		e.green = chan_mag(m, 8);
		e.blue = chan_mag(m, 0);
		e.eor = (out_col == w - 1);
		e.eof = e.eor && (out_row == h - 1);
		if (e.eor) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
		edge_q.push_back(e);
	endfunction

	function automatic void restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	function automatic void predict_pixel(bit cmd, logic [23:0] pix);
		int unsigned w, h, ic, ir;
		logic [23:0] col [3];
		win_t m;
		w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
		h = (cur_height == 0) ? 1 : cur_height;
		if (in_col >= w)
			restart_frame();
		ic = in_col;
		ir = in_row;
		if (ir < h && cmd == CMD_FLUSH)
			return;
		if (ic == 0 && ir >= 2) begin
			for (int k = 0; k < 3; k++) begin
				m[k*3] = window[k*3+1];
				m[k*3+1] = window[k*3+2];
				m[k*3+2] = '0;
			end
			push_edge(m, w, h);
		end
		if (ir >= h + 1) begin
			restart_frame();
			return;
		end
		col[0] = (ir >= 2) ? upper_row[ic] : '0;
		col[1] = (ir >= 1) ? middle_row[ic] : '0;
		col[2] = (ir < h) ? pix : '0;
		if (ir < h) begin
			upper_row[ic] = middle_row[ic];
			middle_row[ic] = pix;
		end
		if (ic == 0)
			for (int k = 0; k < 9; k++)
				window[k] = '0;
		for (int k = 0; k < 3; k++) begin
			window[k*3] = window[k*3+1];
			window[k*3+1] = window[k*3+2];
			window[k*3+2] = col[k];
		end
		if (ic >= 1 && ir >= 1)
			push_edge(window, w, h);
		if (ic + 1 >= w) begin
			in_col = 0;
			in_row = ir + 1;
		end else begin
			in_col = ic + 1;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(bit cmd, logic [23:0] pix);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			pix_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		pix_valid = 1'b1;
		command = cmd;
		{red_in, green_in, blue_in} = pix;
		do @(posedge clk); while (pix_stall);
		predict_pixel(cmd, pix);
		items_sent++;
	endtask

	task automatic release_pixels();
		@(negedge clk);
		pix_valid = 1'b0;
	endtask

	task automatic wait_idle();
		release_pixels();
		while (edge_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_FRAME_WIDTH)
			cur_width = data & 13'h7FF;
		else
			cur_height = data & 13'h1FFF;
		restart_frame();
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_frame(bit partial);
		int unsigned w, h, npix;
		w = (cur_width == 0) ? 1 : (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
		h = (cur_height == 0) ? 1 : cur_height;
		npix = partial ? $urandom_range(0, w * h) : w * h;
		for (int unsigned i = 0; i < npix; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(CMD_FLUSH, 24'($urandom));
			send_item(CMD_PIXEL, {rand_chan(), rand_chan(), rand_chan()});
		end
		if (!partial)
			for (int unsigned i = 0; i <= w; i++)
				send_item(1'($urandom_range(0, 1)), 24'($urandom));
	endtask

	task automatic run_phase(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h, int frames);
		bit partial;
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		for (int f = 0; f < frames; f++) begin
			partial = ($urandom_range(0, 9) == 0);
			run_frame(partial);
			if (partial)
				break;
		end
		wait_idle();
	endtask

	stim_row_t stim_tab [] = '{
		'{1, CFG_FRAME_WIDTH, 13'd1, 0, 0, 0, '0},
		'{1, CFG_FRAME_HEIGHT, 13'd1, 0, 0, 0, '0},
		'{0, 0, 0, CMD_FLUSH, 24'h123456, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'hFF0080, 0, '0},
		'{0, 0, 0, CMD_FLUSH, 24'h000000, 0, '0},
		'{0, 0, 0, CMD_FLUSH, 24'h000000, 1, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1}},
		'{1, CFG_FRAME_WIDTH, 13'd3, 0, 0, 0, '0},
		'{1, CFG_FRAME_HEIGHT, 13'd2, 0, 0, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'hFFFFFF, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'h000000, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'hFFFFFF, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'h00FF00, 0, '0},
		'{0, 0, 0, CMD_FLUSH, 24'h000000, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'hFF00FF, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'h0000FF, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'hABCDEF, 0, '0},
		'{0, 0, 0, CMD_FLUSH, 24'h000000, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'h555555, 0, '0},
		'{0, 0, 0, CMD_FLUSH, 24'h000000, 0, '0},
		'{1, CFG_FRAME_WIDTH, 13'd0, 0, 0, 0, '0},
		'{1, CFG_FRAME_HEIGHT, 13'd0, 0, 0, 0, '0},
		'{0, 0, 0, CMD_PIXEL, 24'h808080, 0, '0},
		'{0, 0, 0, CMD_FLUSH, 24'h000000, 0, '0},
		'{0, 0, 0, CMD_FLUSH, 24'h000000, 1, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1}}
	};

	always @(posedge clk) begin
		edge_res_t got, want;
		if (res_valid && !res_stall) begin
			got = '{red_edge, green_edge, blue_edge, end_of_row, end_of_frame};
			if (edge_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				failed = 1'b1;
			end else begin
				want = edge_q.pop_front();
				if (got !== want) begin
					$display("%0t: expected %h, actual %h", $time, want, got);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		int hold, n_res;
		n_res = 0;
		forever begin
			@(negedge clk);
			if (n_res == 150) begin
				res_stall = 1'b1;
				for (hold = 0; hold < 300; hold++)
					@(negedge clk);
				n_res++;
			end
			res_stall = (pick_gap() != 0);
			@(posedge clk);
			if (res_valid && !res_stall)
				n_res++;
		end
	end

	initial begin
		int idle_count;
		idle_count = 0;
		forever begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				idle_count = 0;
			else
				idle_count++;
			if (idle_count >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int w, h;
		restart_frame();
		for (int k = 0; k < 9; k++)
			window[k] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_tab[i]) begin
			if (stim_tab[i].is_cfg) begin
				wait_idle();
				write_reg(stim_tab[i].idx, stim_tab[i].data);
			end else begin
				send_item(stim_tab[i].cmd, stim_tab[i].pix);
				if (stim_tab[i].known) begin
					void'(edge_q.pop_back());
					edge_q.push_back(stim_tab[i].res);
				end
			end
		end
		wait_idle();

		for (int phase = 0; items_sent < 1000; phase++) begin
			quiet = (phase % 4 == 3);
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 9);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 7);
			run_phase(CFG_DATA_W'(w), CFG_DATA_W'(h), $urandom_range(1, 3));
		end
		quiet = 1'b0;

		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sobel_edge_magnitude_rgb.f =====
hw/rtl/sem_pkg.sv
hw/rtl/sem_ram.sv
hw/rtl/sem_ctrl.sv
hw/rtl/sem_datapath.sv
hw/rtl/sobel_edge_magnitude_rgb.sv
test/testbench.sv
